// File: rtl/core/sps_pkg.sv
package sps_pkg;

	// Longest pattern and longest text, in bytes.
	localparam int MAX_LEN = 255;

	// Width of the pattern length and text counters; they must hold MAX_LEN itself.
	localparam int CNT_W = $clog2(MAX_LEN + 1);

	// Width of the reported position.
	localparam int POS_W = 8;

	// Width used for the position arithmetic before the low bits are taken.
	localparam int CALC_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	// The match vector is reduced in groups; each group ORs GRP_SIZE cells.
	localparam int GRP_SIZE = 16;
	localparam int NUM_GRP  = (MAX_LEN + GRP_SIZE - 1) / GRP_SIZE;
	localparam int PAD_W    = NUM_GRP * GRP_SIZE;

	// Result queue.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2,
		OP_END    = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		TOK_NONE    = 2'd0,
		TOK_BYTE    = 2'd1,
		TOK_END     = 2'd2,
		TOK_RESTART = 2'd3
	} tok_kind_t;

	// Broadcast from the controller to every cell of the chain.
	typedef struct packed {
		logic       clear_pat;
		logic       append;
		logic       text;
		logic       restart;
		logic [7:0] data;
	} cell_ctrl_t;

	// One word travelling down the match-reduction pipeline.
	typedef struct packed {
		tok_kind_t        kind;
		logic [POS_W-1:0] pos;
		logic             force_hit;
		logic             ovf;
	} token_t;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             ovf;
	} result_t;

endpackage

// File: rtl/core/substring_position_search_top.sv
// Substring search: reports the 1-based position of the first occurrence of a
// stored pattern in a streamed text, or 0 when it never occurs.
// Input channel (in_valid/in_ready): each word carries an opcode and a byte.
// Opcode clear empties the pattern, append adds a pattern byte, text feeds one
// text byte, and end closes the text. Only an end word yields a result word on
// the output channel (out_valid/out_ready): match_position and overflow.
// Throughput is one input word per clock while in_ready is high. The pattern
// lives in a chain of MAX_LEN cells, one byte per cell, and every text byte
// updates all candidate bits at once. A result word is offered once its end
// word has passed two token stages, which line it up with the grouped match
// bit of the last text byte, and has been written into the result queue as it
// leaves the second stage.
// When the receiver stalls, results wait in a four-word queue; in_ready drops
// only when the queued results and the end words still in flight already take
// all four entries.
// Reset empties the pattern, the candidate bits, all counters and the queue;
// the pattern bytes themselves are not cleared.
module substring_position_search_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] match_position,
	output logic       overflow
);
	import sps_pkg::*;

	logic                  accept;
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      text_cnt_q;
	logic                  ovf_q;
	cell_ctrl_t            ctrl;
	token_t                tok_d;
	token_t                tok_s1;
	token_t                tok_s2;
	logic [NUM_GRP-1:0]    grp_d;
	logic [NUM_GRP-1:0]    grp_s2;
	logic                  found_q;
	logic [POS_W-1:0]      found_pos_q;
	logic                  final_hit;
	logic                  push;
	result_t               push_data;
	result_t               head;
	logic                  fifo_pop;
	logic [FIFO_CNT_W-1:0] fifo_cnt;
	logic [FIFO_CNT_W-1:0] reserved;
	logic [CALC_W-1:0]     pos_calc;

	logic [MAX_LEN-1:0]    valid_w;
	logic [MAX_LEN-1:0]    cand_w;
	logic [MAX_LEN-1:0]    hit_w;
	logic [PAD_W-1:0]      hit_pad;

	assign accept = in_valid && in_ready;

	// Position of a match ending at the byte being taken: count + 1 - len + 1.
	assign pos_calc = CALC_W'(text_cnt_q) + CALC_W'(2) - CALC_W'(len_q);

	// Decode the accepted word into cell controls, counter updates and a token.
	always_comb begin
		ctrl.clear_pat = 1'b0;
		ctrl.append    = 1'b0;
		ctrl.text      = 1'b0;
		ctrl.restart   = 1'b0;
		ctrl.data      = data_byte;
		tok_d.kind      = TOK_NONE;
		tok_d.pos       = '0;
		tok_d.force_hit = 1'b0;
		tok_d.ovf       = ovf_q;
		if (accept) begin
			unique case (opcode)
				OP_CLEAR: begin
					ctrl.clear_pat = 1'b1;
					ctrl.restart   = 1'b1;
					tok_d.kind     = TOK_RESTART;
				end
				OP_APPEND: begin
					ctrl.append  = 1'b1;
					ctrl.restart = 1'b1;
					tok_d.kind   = TOK_RESTART;
				end
				OP_TEXT: begin
					if (text_cnt_q != CNT_W'(MAX_LEN)) begin
						ctrl.text       = 1'b1;
						tok_d.kind      = TOK_BYTE;
						tok_d.force_hit = (len_q == '0);
						tok_d.pos       = (len_q == '0) ? POS_W'(1) : pos_calc[POS_W-1:0];
					end
				end
				OP_END: begin
					ctrl.restart = 1'b1;
					tok_d.kind   = TOK_END;
				end
				default: begin
					tok_d.kind = TOK_NONE;
				end
			endcase
		end
	end

	// Pattern length, text count and the sticky overflow flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q      <= '0;
			text_cnt_q <= '0;
			ovf_q      <= 1'b0;
		end else if (accept) begin
			unique case (opcode)
				OP_CLEAR: begin
					len_q      <= '0;
					text_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end
				OP_APPEND: begin
					text_cnt_q <= '0;
					if (len_q == CNT_W'(MAX_LEN)) begin
						ovf_q <= 1'b1;
					end else begin
						len_q <= len_q + 1'b1;
					end
				end
				OP_TEXT: begin
					if (text_cnt_q == CNT_W'(MAX_LEN)) begin
						ovf_q <= 1'b1;
					end else begin
						text_cnt_q <= text_cnt_q + 1'b1;
					end
				end
				OP_END: begin
					text_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end
				default: begin
					ovf_q <= ovf_q;
				end
			endcase
		end
	end

	// The cell chain. Cell 0 sees an always-valid, always-matching neighbor.
	for (genvar i = 0; i < MAX_LEN; i++) begin : g_cell
		logic pv;
		logic pc;
		logic nv;
		if (i == 0) begin : g_first
			assign pv = 1'b1;
			assign pc = 1'b1;
		end else begin : g_rest
			assign pv = valid_w[i-1];
			assign pc = cand_w[i-1];
		end
		if (i == MAX_LEN - 1) begin : g_last
			assign nv = 1'b0;
		end else begin : g_mid
			assign nv = valid_w[i+1];
		end
		sps_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.prev_valid (pv),
			.prev_cand  (pc),
			.next_valid (nv),
			.valid      (valid_w[i]),
			.cand       (cand_w[i]),
			.hit        (hit_w[i])
		);
	end

	// Only the last filled cell can flag a hit, so the OR over all cells is the
	// full-match bit. It is reduced in groups and registered.
	assign hit_pad = PAD_W'(hit_w);

	always_comb begin
		for (int g = 0; g < NUM_GRP; g++) begin
			grp_d[g] = |hit_pad[g*GRP_SIZE +: GRP_SIZE];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s1 <= '0;
			tok_s2 <= '0;
		end else begin
			tok_s1 <= tok_d;
			tok_s2 <= tok_s1;
		end
	end

	always_ff @(posedge clk) begin
		grp_s2 <= grp_d;
	end

	// First match wins; an end word closes the text and emits the result.
	assign final_hit = tok_s2.force_hit || (|grp_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q     <= 1'b0;
			found_pos_q <= '0;
		end else begin
			case (tok_s2.kind) inside
				TOK_BYTE: begin
					if (final_hit && !found_q) begin
						found_q     <= 1'b1;
						found_pos_q <= tok_s2.pos;
					end
				end
				TOK_END, TOK_RESTART: begin
					found_q     <= 1'b0;
					found_pos_q <= '0;
				end
				default: begin
					found_q <= found_q;
				end
			endcase
		end
	end

	assign push           = (tok_s2.kind == TOK_END);
	assign push_data.pos  = found_q ? found_pos_q : '0;
	assign push_data.ovf  = tok_s2.ovf;

	sps_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (fifo_pop),
		.not_empty (out_valid),
		.head      (head),
		.count     (fifo_cnt)
	);

	assign fifo_pop       = out_valid && out_ready;
	assign match_position = head.pos;
	assign overflow       = head.ovf;

	// Hold back input while queued results plus end words in flight fill the queue.
	assign reserved = fifo_cnt
		+ FIFO_CNT_W'(tok_s1.kind == TOK_END)
		+ FIFO_CNT_W'(tok_s2.kind == TOK_END);
	assign in_ready = (reserved < FIFO_CNT_W'(FIFO_DEPTH));

endmodule

// File: rtl/core/sps_cell.sv
module sps_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  sps_pkg::cell_ctrl_t ctrl,
	input  logic                prev_valid,
	input  logic                prev_cand,
	input  logic                next_valid,
	output logic                valid,
	output logic                cand,
	output logic                hit
);
	import sps_pkg::*;

	logic       valid_q;
	logic       cand_q;
	logic [7:0] pat_q;

	// A cell holds one pattern byte; the first empty cell takes an appended byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear_pat) begin
			valid_q <= 1'b0;
		end else if (ctrl.append && prev_valid && !valid_q) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.append && prev_valid && !valid_q) begin
			pat_q <= ctrl.data;
		end
	end

	// Candidate bit: the text so far ends with the pattern prefix up to this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= 1'b0;
		end else if (ctrl.restart) begin
			cand_q <= 1'b0;
		end else if (ctrl.text) begin
			cand_q <= prev_cand && (pat_q == ctrl.data);
		end
	end

	assign valid = valid_q;
	assign cand  = cand_q;
	assign hit   = valid_q && !next_valid && cand_q;

endmodule

// File: rtl/core/sps_out_fifo.sv
module sps_out_fifo (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  sps_pkg::result_t                    push_data,
	input  logic                                pop,
	output logic                                not_empty,
	output sps_pkg::result_t                    head,
	output logic [sps_pkg::FIFO_CNT_W-1:0]      count
);
	import sps_pkg::*;

	result_t                 mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q;
	logic [FIFO_PTR_W-1:0]   rd_ptr_q;
	logic [FIFO_CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign count     = cnt_q;

endmodule

// File: sim/sps_result_checker.sv
module sps_result_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [7:0] data_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] match_position,
	input  logic       overflow,
	output int         mismatch_count,
	output int         pending_count
);
	import sps_pkg::*;

	logic [7:0]         pat_bytes [MAX_LEN];
	int unsigned        pat_len;
	// Bit i is set when the last i+1 text bytes equal the first i+1 pattern bytes.
	logic [MAX_LEN-1:0] live_prefix;
	int unsigned        text_len;
	logic               hit_seen;
	int unsigned        hit_start;
	logic               bytes_dropped;
	result_t            awaited_results [$];

	task automatic restart_scan();
		live_prefix = '0;
		text_len    = 0;
		hit_seen    = 1'b0;
		hit_start   = 0;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		opcode_t op;
		result_t want;
		if (!arst_n) begin
			pat_len       = 0;
			bytes_dropped = 1'b0;
			restart_scan();
			awaited_results.delete();
			mismatch_count = 0;
			pending_count  = 0;
		end else begin
			// The result leaving now cannot belong to a word accepted at this same edge.
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("unexpected result word: match_position=%0d overflow=%0b",
							match_position, overflow);
				end else begin
					want = awaited_results.pop_front();
					if (match_position !== want.pos || overflow !== want.ovf) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("mismatch: expected pos=%0d ovf=%0b, got pos=%0d ovf=%0b",
								want.pos, want.ovf, match_position, overflow);
					end
				end
			end

			if (in_valid && in_ready) begin
				op = opcode_t'(opcode);
				case (op)
					OP_CLEAR: begin
						pat_len       = 0;
						bytes_dropped = 1'b0;
						restart_scan();
					end
					OP_APPEND: begin
						restart_scan();
						if (pat_len >= MAX_LEN) begin
							bytes_dropped = 1'b1;
						end else begin
							pat_bytes[pat_len] = data_byte;
							pat_len++;
						end
					end
					OP_TEXT: begin
						if (text_len >= MAX_LEN) begin
							bytes_dropped = 1'b1;
						end else begin
							text_len++;
							if (pat_len == 0) begin
								if (!hit_seen) begin
									hit_seen  = 1'b1;
									hit_start = 1;
								end
							end else begin
								for (int i = pat_len - 1; i > 0; i--)
									live_prefix[i] = live_prefix[i-1] && (pat_bytes[i] == data_byte);
								live_prefix[0] = (pat_bytes[0] == data_byte);
								if (!hit_seen && live_prefix[pat_len-1]) begin
									hit_seen  = 1'b1;
									hit_start = text_len - pat_len + 1;
								end
							end
						end
					end
					OP_END: begin
						want.pos = hit_seen ? POS_W'(hit_start) : '0;
						want.ovf = bytes_dropped;
						awaited_results.push_back(want);
						restart_scan();
						bytes_dropped = 1'b0;
					end
				endcase
			end
			pending_count = awaited_results.size();
		end
	end

endmodule

// File: sim/tb_substring_position_search_top.sv
module tb_substring_position_search_top;
	import sps_pkg::*;

	// Roughly how many words the random part sends before it winds down.
	localparam int ITEM_TARGET = 1100;
	// Cycle limit for the run; the slowest legal run stays far below it.
	localparam int CYCLE_LIMIT = 200000;
	// Length of the one long receiver stall that fills the result queue.
	localparam int HOLD_CYCLES = 400;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] opcode;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] match_position;
	logic       overflow;

	int         mismatch_count;
	int         pending_count;
	int         items_sent;
	int         cycle_count;
	logic       tx_burst;
	logic       rx_burst;
	logic       hold_req;
	// Current pattern as the source sees it, so that text can be built to contain it.
	logic [7:0] pat_copy [$];
	// Two byte values that a sequence draws from most of the time, so that matches are common.
	logic [7:0] alpha0;
	logic [7:0] alpha1;

	substring_position_search_top u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_position (match_position),
		.overflow       (overflow)
	);

	sps_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.data_byte      (data_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_position (match_position),
		.overflow       (overflow),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The run is cut off here if the block stops making progress.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	// Mostly one of the two sequence bytes, sometimes any byte at all.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom);
			3: return alpha1;
			default: return alpha0;
		endcase
	endfunction

	// Offers one word at a falling edge after a random gap and returns at the falling edge
	// that follows its acceptance. With no gap, valid simply stays high into the next word.
	task automatic send_word(input opcode_t op, input logic [7:0] b);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_burst = !tx_burst;
		gap = tx_burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  = 1'b1;
		opcode    = op;
		data_byte = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
		case (op)
			OP_CLEAR: pat_copy.delete();
			OP_APPEND: begin
				if (pat_copy.size() < MAX_LEN)
					pat_copy.push_back(b);
			end
			default: ;
		endcase
	endtask

	// Result side. It takes each result word after a random wait, switches now and then into
	// a stretch of no waiting, and once, when asked, refuses results for a long stretch so that
	// the result queue fills and the block has to stop taking words.
	initial begin : result_sink
		int   wait_cycles;
		logic held;
		out_ready = 1'b0;
		rx_burst  = 1'b0;
		held      = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req && !held) begin
				held      = 1'b1;
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			wait_cycles = rx_burst ? 0 : $urandom_range(0, 8);
			if (wait_cycles > 0) begin
				out_ready = 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (!out_valid);
			@(negedge clk);
		end
	end

	// Word source and verdict.
	initial begin : word_source
		int n_pat;
		int n_text;
		int embed_at;
		int seq_count;
		int roll;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		opcode     = OP_CLEAR;
		data_byte  = 8'h00;
		hold_req   = 1'b0;
		tx_burst   = 1'b0;
		items_sent = 0;
		seq_count  = 0;
		alpha0     = 8'h00;
		alpha1     = 8'h00;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// An empty pattern against an empty text reports no match.
		send_word(OP_END, 8'hFF);
		// An empty pattern matches at the first byte of any non-empty text.
		send_word(OP_TEXT, 8'h00);
		send_word(OP_END, 8'h00);
		// A two-byte pattern with extreme byte values; only the first of two matches counts.
		send_word(OP_APPEND, 8'hFF);
		send_word(OP_APPEND, 8'h00);
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_END, 8'h00);
		// Growing the pattern in the middle of a text throws away the text seen so far.
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_APPEND, 8'hAA);
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_TEXT, 8'hAA);
		send_word(OP_END, 8'h55);
		// Clearing the pattern during a text also restarts the search.
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_CLEAR, 8'h55);
		send_word(OP_END, 8'hAA);
		// A single-byte pattern found at the second text byte.
		send_word(OP_APPEND, 8'h80);
		send_word(OP_TEXT, 8'h01);
		send_word(OP_TEXT, 8'h80);
		send_word(OP_END, 8'h7F);

		// End words back to back while the result side holds off: the queue fills up
		// and the block must stall its input until results drain.
		hold_req = 1'b1;
		repeat (16) send_word(OP_END, 8'($urandom));

		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			seq_count++;
			if (seq_count == 25) begin
				// Full-length text with the only match on the last byte that still fits,
				// so the position reaches its top value, then more bytes that get dropped.
				send_word(OP_CLEAR, 8'($urandom));
				alpha0 = 8'($urandom);
				send_word(OP_APPEND, alpha0);
				repeat (MAX_LEN - 1) send_word(OP_TEXT, alpha0 ^ 8'($urandom_range(1, 255)));
				send_word(OP_TEXT, alpha0);
				repeat (3) send_word(OP_TEXT, alpha0);
				send_word(OP_END, 8'($urandom));
			end else if (seq_count == 45) begin
				// Appends past the pattern capacity are dropped and flagged at the next end.
				send_word(OP_CLEAR, 8'($urandom));
				repeat (MAX_LEN + 2) send_word(OP_APPEND, 8'($urandom));
				repeat (4) send_word(OP_TEXT, 8'($urandom));
				send_word(OP_END, 8'($urandom));
				send_word(OP_CLEAR, 8'($urandom));
			end else begin
				alpha0 = 8'($urandom);
				alpha1 = 8'($urandom);
				// A fresh short pattern, the old one grown by one or two bytes, or the old one.
				roll = $urandom_range(0, 7);
				if (roll < 3 || pat_copy.size() > 6) begin
					send_word(OP_CLEAR, 8'($urandom));
					n_pat = $urandom_range(0, 4);
				end else if (roll < 5) begin
					n_pat = $urandom_range(1, 2);
				end else begin
					n_pat = 0;
				end
				if (pat_copy.size() > 0 && n_pat == 0) begin
					alpha0 = pat_copy[0];
					alpha1 = pat_copy[pat_copy.size() - 1];
				end
				repeat (n_pat) send_word(OP_APPEND, pick_byte());

				// Text from the sequence bytes, half the time with the whole pattern placed in
				// it, and now and then a stray word of any kind in the middle.
				n_text   = $urandom_range(0, 14);
				embed_at = ($urandom_range(0, 1) == 1) ? $urandom_range(0, n_text) : -1;
				for (int k = 0; k <= n_text; k++) begin
					if (k == embed_at) begin
						foreach (pat_copy[j])
							send_word(OP_TEXT, pat_copy[j]);
					end
					if (k < n_text) begin
						if ($urandom_range(0, 19) == 0)
							send_word(opcode_t'($urandom_range(0, 3)), 8'($urandom));
						else
							send_word(OP_TEXT, pick_byte());
					end
				end
				send_word(OP_END, 8'($urandom));
			end
		end
		in_valid = 1'b0;

		// Wait for every outstanding result, then a little longer for anything stray.
		while (pending_count != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (mismatch_count == 0 && pending_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/core/sps_pkg.sv
rtl/core/sps_cell.sv
rtl/core/sps_out_fifo.sv
rtl/core/substring_position_search_top.sv
sim/sps_result_checker.sv
sim/tb_substring_position_search_top.sv
